// ===== sv/mgfw_pkg.sv =====
package mgfw_pkg;

    localparam int SAMPLE_W         = 32;
    localparam int DEF_MAX_FINE_LOG = 9;
    localparam int FINE_LOG_MIN     = 2;
    localparam int FINE_LOG_RESET   = 6;
    localparam int FINE_LOG_W       = 4;
    localparam int COARSE_IDX_W     = 8;
    localparam int OP_QUEUE_DEPTH   = 2;
    localparam int OUT_QUEUE_DEPTH  = 4;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] fine_sample;
        logic                       start_of_grid;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] coarse_value;
        logic [COARSE_IDX_W-1:0]    coarse_row;
        logic [COARSE_IDX_W-1:0]    coarse_col;
        logic                       last_of_grid;
    } t_out_item;

    // Classified sample handed from the front to the back
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       emit;
        logic [COARSE_IDX_W-1:0]    coarse_row;
        logic [COARSE_IDX_W-1:0]    coarse_col;
        logic                       last;
    } t_op;

endpackage

// ===== sv/mgfw_queue.sv =====
module mgfw_queue
    import mgfw_pkg::*;
#(
    parameter int DEPTH = OP_QUEUE_DEPTH,
    parameter int WIDTH = $bits(t_op)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_empty,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNTW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CNTW-1:0]  r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CNTW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ===== sv/mgfw_front.sv =====
module mgfw_front
    import mgfw_pkg::*;
#(
    parameter int MAX_FINE_LOG = DEF_MAX_FINE_LOG
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_we,
    input  logic [FINE_LOG_W-1:0]   i_cfg_data,
    input  logic                    i_accept,
    input  t_in_item                i_item,
    output t_op                     o_op,
    output logic [MAX_FINE_LOG:0]   o_col
);

    localparam int CW = MAX_FINE_LOG + 1;

    logic [FINE_LOG_W-1:0] r_fine_log;
    logic [CW-1:0]         r_row, r_col;
    logic [FINE_LOG_W-1:0] lg;
    logic [CW-1:0]         side, side_m2, row, col, row_m1, col_m1;
    logic [CW-1:0]         n_row, n_col;
    logic [CW+7:0]         row_ext, col_ext;

    always_comb begin
        lg = r_fine_log;
        if (lg < FINE_LOG_W'(FINE_LOG_MIN)) lg = FINE_LOG_W'(FINE_LOG_MIN);
        if (lg > FINE_LOG_W'(MAX_FINE_LOG)) lg = FINE_LOG_W'(MAX_FINE_LOG);
        side    = (CW'(1) << lg) + CW'(1);
        side_m2 = side - CW'(2);

        // Restart at a grid mark, or when a counter sits at or past a shrunken side
        row = i_item.start_of_grid ? '0 : r_row;
        col = i_item.start_of_grid ? '0 : r_col;
        if (row >= side) row = '0;
        if (col >= side) col = '0;

        row_m1  = row - CW'(1);
        col_m1  = col - CW'(1);
        row_ext = (CW+8)'(row_m1 >> 1);
        col_ext = (CW+8)'(col_m1 >> 1);

        o_op.sample     = i_item.fine_sample;
        o_op.emit       = (row >= CW'(3)) && (col >= CW'(3)) && row[0] && col[0]
                          && (row <= side_m2) && (col <= side_m2);
        o_op.coarse_row = row_ext[COARSE_IDX_W-1:0];
        o_op.coarse_col = col_ext[COARSE_IDX_W-1:0];
        o_op.last       = (row == side_m2) && (col == side_m2);
        o_col           = col;

        n_row = row;
        n_col = col + CW'(1);
        if (n_col >= side) begin
            n_col = '0;
            n_row = row + CW'(1);
            if (n_row >= side) n_row = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fine_log <= FINE_LOG_W'(FINE_LOG_RESET);
            r_row      <= '0;
            r_col      <= '0;
        end else begin
            if (i_cfg_we) begin
                r_fine_log <= i_cfg_data;
            end
            if (i_accept) begin
                r_row <= n_row;
                r_col <= n_col;
            end
        end
    end

endmodule

// ===== sv/mgfw_back.sv =====
module mgfw_back
    import mgfw_pkg::*;
#(
    parameter int MAX_FINE_LOG = DEF_MAX_FINE_LOG
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_op_valid,
    input  t_op                   i_op,
    input  logic [MAX_FINE_LOG:0] i_col,
    output logic                  o_op_pop,
    input  logic                  i_out_full,
    output logic                  o_out_push,
    output t_out_item             o_out
);

    localparam int CW    = MAX_FINE_LOG + 1;
    localparam int DEPTH = (1 << MAX_FINE_LOG) + 1;
    localparam int SUMW  = SAMPLE_W + 4;

    logic signed [SAMPLE_W-1:0] r_store_a [DEPTH];
    logic signed [SAMPLE_W-1:0] r_store_b [DEPTH];
    logic signed [SAMPLE_W-1:0] r_win [6];
    logic signed [SAMPLE_W-1:0] r_rd_a, r_rd_b, r_fwd_a, r_fwd_b;
    logic                       r_fwd;
    logic                       r_b_valid;
    t_op                        r_b_op;
    logic [CW-1:0]              r_b_col;

    logic                       commit, load;
    logic signed [SAMPLE_W-1:0] top, mid;
    logic signed [SUMW-1:0]     edges, corners, sum;

    assign commit   = r_b_valid && (!r_b_op.emit || !i_out_full);
    assign load     = i_op_valid && (!r_b_valid || commit);
    assign o_op_pop = load;

    // Take the row just written when the same column comes back to back
    assign top = r_fwd ? r_fwd_a : r_rd_a;
    assign mid = r_fwd ? r_fwd_b : r_rd_b;

    always_comb begin
        edges   = SUMW'(r_win[1]) + SUMW'(mid) + SUMW'(r_win[3]) + SUMW'(r_win[5]);
        corners = SUMW'(r_win[0]) + SUMW'(r_win[2]) + SUMW'(top) + SUMW'(r_b_op.sample);
        sum     = (SUMW'(r_win[4]) <<< 2) + (edges <<< 1) + corners;

        o_out.coarse_value = sum[SUMW-1:4];
        o_out.coarse_row   = r_b_op.coarse_row;
        o_out.coarse_col   = r_b_op.coarse_col;
        o_out.last_of_grid = r_b_op.last;
    end

    assign o_out_push = commit && r_b_op.emit;

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rd_a <= r_store_a[i_col];
            r_rd_b <= r_store_b[i_col];
        end
        if (commit) begin
            r_store_a[r_b_col] <= mid;
            r_store_b[r_b_col] <= r_b_op.sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_b_op  <= i_op;
            r_b_col <= i_col;
            r_fwd_a <= mid;
            r_fwd_b <= r_b_op.sample;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
            r_fwd     <= 1'b0;
            for (int k = 0; k < 6; k++) begin
                r_win[k] <= '0;
            end
        end else begin
            if (load) begin
                r_b_valid <= 1'b1;
                r_fwd     <= commit && (i_col == r_b_col);
            end else if (commit) begin
                r_b_valid <= 1'b0;
            end
            if (commit) begin
                r_win[0] <= r_win[3];
                r_win[1] <= r_win[4];
                r_win[2] <= r_win[5];
                r_win[3] <= top;
                r_win[4] <= mid;
                r_win[5] <= r_b_op.sample;
            end
        end
    end

endmodule

// ===== sv/multigrid_full_weighting_restrict.sv =====
// Full-weighting restriction of a streamed square fine residual grid.
// Input channel: drive i_in (fine_sample, start_of_grid) with i_push; an item
// is taken at a clock edge where i_push is high and o_full is low. Feed the
// fine grid in row-major order; start_of_grid on sample (0,0) restarts the
// row and column counters.
// Result channel: while o_empty is low, o_out holds the oldest coarse point
// (value, row, col, last_of_grid); i_pop takes it at that edge.
// Configuration: i_cfg_we writes i_cfg_data into fine_log (side 2^fine_log+1),
// saturated to 2..MAX_FINE_LOG; write it only while the block is idle.
// Throughput: one fine sample per cycle while the result queue has room;
// each line store takes one read as a sample enters the back stage and one
// write as the sample before it leaves. The result for fine sample
// (2i+1, 2j+1) passes through the op queue, back stage and result queue.
// When the receiver stalls, the result queue absorbs a few items, then the
// back stage holds, the op queue fills and o_full rises; nothing is dropped.
// Reset (synchronous, active low) empties both queues, clears the counters and
// the window, and sets fine_log to 6. The line stores are not cleared.
module multigrid_full_weighting_restrict
    import mgfw_pkg::*;
#(
    parameter int MAX_FINE_LOG = DEF_MAX_FINE_LOG
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [FINE_LOG_W-1:0] i_cfg_data,
    input  logic                  i_push,
    input  t_in_item              i_in,
    output logic                  o_full,
    output logic                  o_empty,
    input  logic                  i_pop,
    output t_out_item             o_out
);

    localparam int CW   = MAX_FINE_LOG + 1;
    localparam int OP_W = CW + $bits(t_op);

    logic          in_accept;
    t_op           front_op, back_op;
    logic [CW-1:0] front_col, back_col;
    logic [OP_W-1:0] op_q_out;
    logic          op_empty, op_pop;
    logic          out_full, out_push;
    t_out_item     back_out;
    logic [$bits(t_out_item)-1:0] out_q_out;

    assign in_accept = i_push && !o_full;

    // Front: count positions and classify each sample
    mgfw_front #(
        .MAX_FINE_LOG (MAX_FINE_LOG)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_accept   (in_accept),
        .i_item     (i_in),
        .o_op       (front_op),
        .o_col      (front_col)
    );

    // Decouple the front from the back
    mgfw_queue #(
        .DEPTH (OP_QUEUE_DEPTH),
        .WIDTH (OP_W)
    ) u_op_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_data  ({front_col, front_op}),
        .o_full  (o_full),
        .o_empty (op_empty),
        .i_pop   (op_pop),
        .o_data  (op_q_out)
    );

    assign back_col = op_q_out[OP_W-1 -: CW];
    assign back_op  = t_op'(op_q_out[$bits(t_op)-1:0]);

    // Back: line stores, 3x3 window and weighted sum
    mgfw_back #(
        .MAX_FINE_LOG (MAX_FINE_LOG)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_op_valid (!op_empty),
        .i_op       (back_op),
        .i_col      (back_col),
        .o_op_pop   (op_pop),
        .i_out_full (out_full),
        .o_out_push (out_push),
        .o_out      (back_out)
    );

    // Hold finished results for the receiver
    mgfw_queue #(
        .DEPTH (OUT_QUEUE_DEPTH),
        .WIDTH ($bits(t_out_item))
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (back_out),
        .o_full  (out_full),
        .o_empty (o_empty),
        .i_pop   (i_pop),
        .o_data  (out_q_out)
    );

    assign o_out = t_out_item'(out_q_out);

    // Never push a result into a full result queue
    a_no_out_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_push |-> !out_full)
        else $error("result pushed into full result queue");

    // The back stage takes ops only when the op queue holds one
    a_no_op_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        op_pop |-> !op_empty)
        else $error("op taken from empty op queue");

    // The final coarse point of a grid lies on the diagonal
    a_last_diag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!o_empty && o_out.last_of_grid) |-> (o_out.coarse_row == o_out.coarse_col))
        else $error("last point of grid off the diagonal");

    // Reset leaves no result waiting
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> o_empty)
        else $error("result queue not empty after reset");

endmodule

// ===== tb/multigrid_full_weighting_restrict_check.sv =====
module multigrid_full_weighting_restrict_check
    import mgfw_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [FINE_LOG_W-1:0] i_cfg_data,
    input  logic                  i_push,
    input  logic                  i_full,
    input  t_in_item              i_in,
    input  logic                  i_empty,
    input  logic                  i_pop,
    input  t_out_item             i_out,
    output int                    o_errors,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LINE_LEN = (1 << DEF_MAX_FINE_LOG) + 1;

    logic [FINE_LOG_W-1:0]      fine_log_q;
    logic signed [SAMPLE_W-1:0] upper_line [LINE_LEN];
    logic signed [SAMPLE_W-1:0] middle_line [LINE_LEN];
    logic signed [SAMPLE_W-1:0] window [6];
    int unsigned                row_pos;
    int unsigned                col_pos;
    t_out_item                  coarse_due [$];
    int                         errors;

    initial begin
        foreach (upper_line[k]) upper_line[k] = '0;
        foreach (middle_line[k]) middle_line[k] = '0;
    end

    // Advance the fine raster by one sample; queue the coarse point it completes.
    task automatic restrict_sample(input t_in_item item);
        int unsigned                lg;
        int unsigned                side;
        int unsigned                r;
        int unsigned                c;
        longint                     total;
        logic signed [SAMPLE_W-1:0] top;
        logic signed [SAMPLE_W-1:0] mid;
        logic signed [SAMPLE_W-1:0] x;
        t_out_item                  point;
        lg = fine_log_q;
        if (lg < FINE_LOG_MIN) lg = FINE_LOG_MIN;
        if (lg > DEF_MAX_FINE_LOG) lg = DEF_MAX_FINE_LOG;
        side = (1 << lg) + 1;
        if (item.start_of_grid) begin
            row_pos = 0;
            col_pos = 0;
        end
        if (row_pos >= side) row_pos = 0;
        if (col_pos >= side) col_pos = 0;
        r = row_pos;
        c = col_pos;
        x = item.fine_sample;
        top = upper_line[c];
        mid = middle_line[c];
        if (r >= 3 && c >= 3 && (r % 2) == 1 && (c % 2) == 1
            && r <= side - 2 && c <= side - 2) begin
            total = 4 * longint'(window[4])
                  + 2 * (longint'(window[1]) + longint'(mid) + longint'(window[3])
                         + longint'(window[5]))
                  + longint'(window[0]) + longint'(window[2]) + longint'(top) + longint'(x);
            point.coarse_value = SAMPLE_W'(total >>> 4);
            point.coarse_row   = COARSE_IDX_W'((r - 1) >> 1);
            point.coarse_col   = COARSE_IDX_W'((c - 1) >> 1);
            point.last_of_grid = (r == side - 2 && c == side - 2);
            coarse_due.push_back(point);
        end
        window[0] = window[3];
        window[1] = window[4];
        window[2] = window[5];
        window[3] = top;
        window[4] = mid;
        window[5] = x;
        upper_line[c] = mid;
        middle_line[c] = x;
        c++;
        if (c >= side) begin
            c = 0;
            r++;
            if (r >= side) r = 0;
        end
        row_pos = r;
        col_pos = c;
    endtask

    always @(posedge i_clk) begin
        t_out_item want;
        if (!i_rst_n) begin
            fine_log_q = FINE_LOG_W'(FINE_LOG_RESET);
            row_pos = 0;
            col_pos = 0;
            foreach (window[k]) window[k] = '0;
            coarse_due.delete();
        end else begin
            // results leave before the item of this edge can add one
            if (i_pop && !i_empty) begin
                if (coarse_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected coarse point: value %0d row %0d col %0d last %0b",
                             $time, i_out.coarse_value, i_out.coarse_row, i_out.coarse_col,
                             i_out.last_of_grid);
                end else begin
                    want = coarse_due.pop_front();
                    if (want.coarse_value !== i_out.coarse_value ||
                        want.coarse_row !== i_out.coarse_row ||
                        want.coarse_col !== i_out.coarse_col ||
                        want.last_of_grid !== i_out.last_of_grid) begin
                        errors++;
                        $display({"%0t: coarse point mismatch: expected value %0d row %0d col %0d",
                                  " last %0b, got value %0d row %0d col %0d last %0b"},
                                 $time, want.coarse_value, want.coarse_row, want.coarse_col,
                                 want.last_of_grid, i_out.coarse_value, i_out.coarse_row,
                                 i_out.coarse_col, i_out.last_of_grid);
                    end
                end
            end
            if (i_push && !i_full) restrict_sample(i_in);
            // a write takes effect after this edge
            if (i_cfg_we) fine_log_q = i_cfg_data;
        end
        o_errors <= errors;
        o_pending <= coarse_due.size();
    end

endmodule

// ===== tb/multigrid_full_weighting_restrict_test.sv =====
module multigrid_full_weighting_restrict_test;
    import mgfw_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    // Random fine samples to push after the directed part.
    localparam int SAMPLE_BUDGET = 980;
    // Cycles to hold after the last expected point before a write or the verdict.
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 20;
    // Cycles in a row with no item moving on either side before giving up.
    localparam int STALL_LIMIT   = 1000;
    // Largest side used for full grids in the random part.
    localparam int SMALL_SIDE    = 17;
    // Grid used for the directed wide-row part (side 129).
    localparam int WIDE_LOG      = 7;

    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_W-1){1'b1}}};
    localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_W-1){1'b0}}};

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [FINE_LOG_W-1:0] i_cfg_data = FINE_LOG_W'(FINE_LOG_RESET);
    logic                  i_push     = 1'b0;
    t_in_item              i_in       = '0;
    logic                  i_pop      = 1'b0;
    logic                  o_full;
    logic                  o_empty;
    t_out_item             o_out;

    int                    errors;
    int                    pending;
    int                    send_idle_pct = 21;
    int                    take_idle_pct = 58;
    int                    quiet_cycles  = 0;
    int                    cur_side      = (1 << FINE_LOG_RESET) + 1;
    int unsigned           sent_count    = 0;

    always #5 i_clk = ~i_clk;

    multigrid_full_weighting_restrict DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_push     (i_push),
        .i_in       (i_in),
        .o_full     (o_full),
        .o_empty    (o_empty),
        .i_pop      (i_pop),
        .o_out      (o_out)
    );

    // The checker watches both channels and the register port, predicts every
    // coarse point and hands back its failure count and the points still due.
    multigrid_full_weighting_restrict_check checker_inst (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_push     (i_push),
        .i_full     (o_full),
        .i_in       (i_in),
        .i_empty    (o_empty),
        .i_pop      (i_pop),
        .i_out      (o_out),
        .o_errors   (errors),
        .o_pending  (pending)
    );

    // Receiver: stall at random, at the rate of the current phase.
    always @(posedge i_clk) begin
        i_pop <= ($urandom_range(99) >= take_idle_pct);
    end

    // Watchdog: drop the run if nothing moves for too long.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_push && !o_full) || (i_pop && !o_empty)) begin
                quiet_cycles <= 0;
            end else if (quiet_cycles >= STALL_LIMIT) begin
                $display("multigrid_full_weighting_restrict test failed");
                $finish;
            end else begin
                quiet_cycles <= quiet_cycles + 1;
            end
        end
    end

    // Side length the block uses for a register value: out-of-range values
    // saturate into the legal window.
    function automatic int side_for(input logic [FINE_LOG_W-1:0] value);
        int lg;
        lg = value;
        if (lg < FINE_LOG_MIN) lg = FINE_LOG_MIN;
        if (lg > DEF_MAX_FINE_LOG) lg = DEF_MAX_FINE_LOG;
        return (1 << lg) + 1;
    endfunction

    // Mostly wide random samples, with the extremes and small values mixed in
    // so that the floor rounding sees both signs near zero.
    function automatic logic signed [SAMPLE_W-1:0] random_sample();
        unique case ($urandom_range(9))
            0:       return SAMPLE_MAX;
            1:       return SAMPLE_MIN;
            2, 3:    return SAMPLE_W'($urandom_range(64) - 32);
            default: return SAMPLE_W'($urandom());
        endcase
    endfunction

    // Sides 5 and 9 are cheap; 17 shows up now and then.
    function automatic logic [FINE_LOG_W-1:0] pick_small_log();
        int pick;
        pick = $urandom_range(9);
        if (pick < 4) return FINE_LOG_W'(2);
        if (pick < 8) return FINE_LOG_W'(3);
        return FINE_LOG_W'(4);
    endfunction

    // Values below the legal range or above the largest supported grid.
    function automatic logic [FINE_LOG_W-1:0] out_of_range_log();
        int pick;
        pick = $urandom_range(7);
        return (pick < 2) ? FINE_LOG_W'(pick) : FINE_LOG_W'(pick + 8);
    endfunction

    // Present one item, idling first at the phase rate; return at the edge
    // that takes it, with push still high so back-to-back items stream.
    task automatic push_item(input logic signed [SAMPLE_W-1:0] value, input logic mark);
        while ($urandom_range(99) < send_idle_pct) begin
            i_push <= 1'b0;
            @(posedge i_clk);
        end
        i_push <= 1'b1;
        i_in <= t_in_item'{fine_sample: value, start_of_grid: mark};
        @(posedge i_clk);
        while (o_full) @(posedge i_clk);
        sent_count++;
    endtask

    // Hold the sender until every predicted point has come out, then give
    // the back stage time to retire items that make no point.
    task automatic hold_until_drained();
        i_push <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Write fine_log only with the block idle.
    task automatic write_fine_log(input logic [FINE_LOG_W-1:0] value);
        hold_until_drained();
        i_cfg_we <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cur_side = side_for(value);
    endtask

    // Stream random samples; the first carries first_mark and, when
    // noise_odds is nonzero, later ones carry a stray start mark at 1 in noise_odds.
    task automatic send_samples(input int count, input logic first_mark, input int noise_odds);
        logic mark;
        for (int k = 0; k < count; k++) begin
            if (k == 0) mark = first_mark;
            else mark = (noise_odds != 0) && ($urandom_range(noise_odds - 1) == 0);
            push_item(random_sample(), mark);
        end
    endtask

    // One stretch of random stimulus. Every stretch opens with a start mark
    // except where it deliberately continues a grid, so no line-store entry
    // is ever read before the current grid has written it.
    task automatic run_episode();
        int kind;
        int count;
        kind = $urandom_range(99);
        if (kind < 60) begin
            // Whole grids, sometimes two in a row; the second either carries
            // its own start mark or relies on the counters wrapping.
            if (cur_side > SMALL_SIDE || $urandom_range(1) == 0) write_fine_log(pick_small_log());
            count = cur_side * cur_side;
            send_samples(count, 1'b1, 0);
            if ($urandom_range(1) == 0) send_samples(count, 1'($urandom_range(1)), 0);
        end else if (kind < 75) begin
            // Cut-short grid with stray start marks inside it.
            if (cur_side > SMALL_SIDE) write_fine_log(pick_small_log());
            send_samples($urandom_range(1, cur_side * cur_side - 1), 1'b1, 16);
        end else if (kind < 90) begin
            // Saturated register value, then a short run at that size.
            write_fine_log(out_of_range_log());
            send_samples($urandom_range(1, 40), 1'b1, 0);
        end else begin
            // Shrink the grid part way through: the counters may land at or beyond
            // the new side and restart, reading stores the old rows wrote.
            write_fine_log(FINE_LOG_W'(4));
            send_samples(cur_side * $urandom_range(1, 8) + $urandom_range(0, 16), 1'b1, 0);
            write_fine_log(FINE_LOG_W'($urandom_range(2, 3)));
            send_samples($urandom_range(20, 60), 1'b0, 0);
        end
    endtask

    initial begin
        int unsigned random_start;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: a below-range value saturates to the smallest grid. One grid
        // of all-maximum samples, then a second of all-minimum samples with no
        // start mark, so the counters must wrap on their own. Both weighted
        // sums hit the extremes of the result exactly.
        write_fine_log(FINE_LOG_W'(0));
        for (int k = 0; k < 25; k++) push_item(SAMPLE_MAX, k == 0);
        for (int k = 0; k < 25; k++) push_item(SAMPLE_MIN, 1'b0);

        // Wide grid: four full rows, enough to finish the first coarse row
        // across the far columns of both line stores.
        write_fine_log(FINE_LOG_W'(WIDE_LOG));
        send_samples(4 * cur_side, 1'b1, 0);

        // Random part in three idling phases: sender light and receiver heavy,
        // then the reverse, then both streaming flat out.
        random_start = sent_count;
        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 21 : (phase == 1) ? 58 : 0;
            take_idle_pct = (phase == 0) ? 58 : (phase == 1) ? 21 : 0;
            while (sent_count - random_start < SAMPLE_BUDGET * (phase + 1) / 3) run_episode();
        end

        // Drain and let any stray point show up before the verdict.
        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (errors == 0) begin
            $display("multigrid_full_weighting_restrict test passed");
        end else begin
            $display("multigrid_full_weighting_restrict test failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/mgfw_pkg.sv
sv/mgfw_queue.sv
sv/mgfw_front.sv
sv/mgfw_back.sv
sv/multigrid_full_weighting_restrict.sv
tb/multigrid_full_weighting_restrict_check.sv
tb/multigrid_full_weighting_restrict_test.sv
